[design/dopr_pkg.sv]
// ----------------------------------------------------------------------------
// Dissolved-oxygen pump regulator package
// Register indexes, field widths and the flag state shared by the regulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dopr_pkg;

  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned TICKS_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_REGULATION  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REST_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_TICKS = 3'd4;

  localparam logic [TICKS_W-1:0] REST_PERIOD_RESET = 16'd900;
  localparam logic [TICKS_W-1:0] BURST_TICKS_RESET = 16'd60;

  typedef struct packed {
    logic regulation_enable;
    logic [LIMIT_W-1:0] lower_limit;
    logic [LIMIT_W-1:0] upper_limit;
    logic [TICKS_W-1:0] rest_period_ticks;
    logic [TICKS_W-1:0] burst_ticks;
  } cfg_t;

  typedef struct packed {
    logic pump_state;
    logic oxygen_state;
    logic rising_flag;
    logic falling_flag;
    logic rest_flag;
    logic period_running;
    logic burst_running;
    logic stop_request;
    logic first_rest_tick;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    pump_state:      1'b0,
    oxygen_state:    1'b0,
    rising_flag:     1'b0,
    falling_flag:    1'b0,
    rest_flag:       1'b0,
    period_running:  1'b0,
    burst_running:   1'b0,
    stop_request:    1'b0,
    first_rest_tick: 1'b1
  };

endpackage

`default_nettype wire

[design/dopr_tick.sv]
// ----------------------------------------------------------------------------
// Regulation tick logic
// Computes the next flags and counters for one tick: period timer, burst
// timer, rest-mode handler and band check, in that order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dopr_tick #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire dopr_pkg::cfg_t                 cfg,
  input  wire dopr_pkg::flags_t               flags,
  input  wire logic [COUNT_WIDTH-1:0]         period_count,
  input  wire logic [COUNT_WIDTH-1:0]         burst_count,
  input  wire logic [dopr_pkg::LEVEL_W-1:0]   oxygen_level,
  input  wire logic                           sample_valid,
  output dopr_pkg::flags_t                    flags_next,
  output logic [COUNT_WIDTH-1:0]              period_count_next,
  output logic [COUNT_WIDTH-1:0]              burst_count_next
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > dopr_pkg::TICKS_W) ? COUNT_WIDTH : dopr_pkg::TICKS_W;

  logic [COUNT_WIDTH-1:0] period_inc;
  logic [CMP_W-1:0]       period_cmp;
  logic [CMP_W-1:0]       burst_cmp;
  logic [CMP_W-1:0]       rest_period_cmp;
  logic [CMP_W-1:0]       burst_ticks_cmp;

  assign rest_period_cmp = CMP_W'(cfg.rest_period_ticks);
  assign burst_ticks_cmp = CMP_W'(cfg.burst_ticks);
  assign period_inc      = period_count + COUNT_WIDTH'(1);
  assign period_cmp      = CMP_W'(period_inc);

  always_comb begin
    flags_next        = flags;
    period_count_next = period_count;
    burst_count_next  = burst_count;
    burst_cmp         = '0;

    if (flags_next.period_running) begin
      if (period_cmp == rest_period_cmp) begin
        period_count_next        = '0;
        flags_next.pump_state    = 1'b1;
        flags_next.burst_running = 1'b1;
      end else begin
        period_count_next = period_inc;
      end
    end else begin
      period_count_next = '0;
    end

    if (flags_next.burst_running) begin
      burst_count_next = burst_count + COUNT_WIDTH'(1);
    end else begin
      burst_count_next = '0;
    end
    burst_cmp = CMP_W'(burst_count_next);
    if (burst_cmp == burst_ticks_cmp) begin
      burst_count_next         = '0;
      flags_next.stop_request  = 1'b1;
      flags_next.burst_running = 1'b0;
    end

    if (flags_next.rest_flag) begin
      flags_next.oxygen_state   = 1'b0;
      flags_next.period_running = 1'b1;
      if (flags_next.first_rest_tick) begin
        flags_next.stop_request    = 1'b1;
        flags_next.first_rest_tick = 1'b0;
      end
      if (flags_next.stop_request) begin
        flags_next.pump_state   = 1'b0;
        flags_next.stop_request = 1'b0;
      end
    end else begin
      flags_next.period_running  = 1'b0;
      flags_next.burst_running   = 1'b0;
      flags_next.first_rest_tick = 1'b1;
    end

    if (cfg.regulation_enable && sample_valid) begin
      if (cfg.lower_limit < oxygen_level && cfg.upper_limit > oxygen_level &&
          !flags_next.falling_flag && !flags_next.rising_flag) begin
        flags_next.rest_flag = 1'b1;
      end
      if (cfg.lower_limit > oxygen_level) begin
        flags_next.rising_flag    = 1'b1;
        flags_next.falling_flag   = 1'b0;
        flags_next.pump_state     = 1'b1;
        flags_next.oxygen_state   = 1'b1;
        flags_next.rest_flag      = 1'b0;
        flags_next.period_running = 1'b0;
        flags_next.burst_running  = 1'b0;
      end
      if (cfg.upper_limit < oxygen_level) begin
        flags_next.rest_flag    = 1'b1;
        flags_next.falling_flag = 1'b1;
        flags_next.rising_flag  = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/dissolved_oxygen_pump_regulator.sv]
// ----------------------------------------------------------------------------
// Dissolved-oxygen pump regulator
// An accepted item passes an input register and then a result register
// before its result is valid; m_axis_tready back-pressure can hold it there.
// Throughput is one item per cycle while the output is not stalled; the tick
// logic lies between the input register and the result register.
// Synchronous active-high reset clears the counters, sets first_rest_tick,
// clears the other flags, sets the rest period to 900 and the burst to 60 ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dissolved_oxygen_pump_regulator #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [15:0]                       s_axis_tdata,  // oxygen_level
  input  wire logic                              s_axis_tuser,  // sample_valid
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // pump_drive, oxygen_request, rising_mode, falling_mode, rest_mode, zeros
  output logic [7:0]                             m_axis_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dopr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dopr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  dopr_pkg::cfg_t   cfg;
  dopr_pkg::flags_t flags;
  dopr_pkg::flags_t flags_next;

  logic [COUNT_WIDTH-1:0]        period_count;
  logic [COUNT_WIDTH-1:0]        period_count_next;
  logic [COUNT_WIDTH-1:0]        burst_count;
  logic [COUNT_WIDTH-1:0]        burst_count_next;

  logic                          in_valid;
  logic [dopr_pkg::LEVEL_W-1:0]  in_level;
  logic                          in_sample_valid;
  logic                          out_free;
  logic                          advance;
  logic [4:0]                    result;

  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.regulation_enable <= 1'b0;
      cfg.lower_limit       <= '0;
      cfg.upper_limit       <= '0;
      cfg.rest_period_ticks <= dopr_pkg::REST_PERIOD_RESET;
      cfg.burst_ticks       <= dopr_pkg::BURST_TICKS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dopr_pkg::REG_REGULATION:  cfg.regulation_enable <= cfg_data[0];
        dopr_pkg::REG_LOWER_LIMIT: cfg.lower_limit       <= cfg_data;
        dopr_pkg::REG_UPPER_LIMIT: cfg.upper_limit       <= cfg_data;
        dopr_pkg::REG_REST_PERIOD: cfg.rest_period_ticks <= cfg_data;
        dopr_pkg::REG_BURST_TICKS: cfg.burst_ticks       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level        <= s_axis_tdata;
      in_sample_valid <= s_axis_tuser;
    end
  end

  dopr_tick #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tick (
    .cfg               (cfg),
    .flags             (flags),
    .period_count      (period_count),
    .burst_count       (burst_count),
    .oxygen_level      (in_level),
    .sample_valid      (in_sample_valid),
    .flags_next        (flags_next),
    .period_count_next (period_count_next),
    .burst_count_next  (burst_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags         <= dopr_pkg::FLAGS_RESET;
      period_count  <= '0;
      burst_count   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        flags        <= flags_next;
        period_count <= period_count_next;
        burst_count  <= burst_count_next;
      end
      if (out_free) begin
        m_axis_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= {flags_next.rest_flag, flags_next.falling_flag,
                 flags_next.rising_flag, flags_next.oxygen_state,
                 flags_next.pump_state};
    end
  end

  assign m_axis_tdata = {3'b000, result};

endmodule

`default_nettype wire
